[hdl/lcm_pkg.sv]
// Shared types and constants for the LC meter value pipeline.
`default_nettype none
package lcm_pkg;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IND_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_SCALE = 2'd3;
    localparam logic OP_INDUCTANCE  = 1'b0;
    localparam logic OP_CAPACITANCE = 1'b1;

    // classified item handed from front to back
    typedef struct packed {
        logic [31:0] ref_sq;
        logic [15:0] count;
        logic [15:0] scale;
        logic        zero;
        logic        clamped;
    } t_job;

    typedef struct packed {
        logic [31:0] value;
        logic        saturated;
        logic        clamped;
    } t_res;
endpackage
`default_nettype wire

[hdl/lc_meter_value_compute.sv]
// Top level of the LC meter value pipeline.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------
//  item in   | i_start / o_busy      | i_operation, i_measured_count
//  config    | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//  result    | o_result_strobe       | o_value, flags, o_digit0..7
//
// One item is accepted every cycle; o_busy stays low. An item passes
// the front stage, the queue, the first divider, the multiply stage, the
// second divider, the saturate stage and the digit stages in that order;
// both dividers are bit-per-stage. Reset clears all valid bits and loads register
// defaults. Results show for one cycle and cannot be held off.
`default_nettype none
module lc_meter_value_compute
    import lcm_pkg::*;
#(
    parameter int unsigned DIGIT_COUNT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_operation,
    input  wire logic [15:0] i_measured_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_result_strobe,
    output logic [31:0]      o_value,
    output logic             o_saturated,
    output logic             o_count_clamped,
    output logic [3:0]       o_digit0,
    output logic [3:0]       o_digit1,
    output logic [3:0]       o_digit2,
    output logic [3:0]       o_digit3,
    output logic [3:0]       o_digit4,
    output logic [3:0]       o_digit5,
    output logic [3:0]       o_digit6,
    output logic [3:0]       o_digit7
);
    logic [15:0] r_reference;
    logic [15:0] r_floor;
    logic [15:0] r_ind_scale;
    logic [15:0] r_cap_scale;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // register file; unknown indexes cannot occur with a two-bit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference <= 16'd0;
            r_floor     <= 16'd65;
            r_ind_scale <= 16'd1000;
            r_cap_scale <= 16'd2000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_REFERENCE: r_reference <= i_cfg_data;
                REG_FLOOR:     r_floor     <= i_cfg_data;
                REG_IND_SCALE: r_ind_scale <= i_cfg_data;
                REG_CAP_SCALE: r_cap_scale <= i_cfg_data;
                default:       r_reference <= r_reference;
            endcase
        end
    end

    logic w_accept;
    assign w_accept = i_start && !o_busy;

    logic w_f_valid;
    t_job w_f_job;
    lcm_front u_front (
        .i_clk, .i_rst_n, .i_valid(w_accept), .i_operation, .i_measured_count,
        .i_reference(r_reference), .i_floor(r_floor),
        .i_ind_scale(r_ind_scale), .i_cap_scale(r_cap_scale),
        .o_valid(w_f_valid), .o_job(w_f_job)
    );

    logic w_q_valid;
    t_job w_q_job;
    lcm_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(w_f_valid), .i_job(w_f_job),
        .o_valid(w_q_valid), .o_job(w_q_job)
    );

    logic w_b_valid;
    t_res w_b_res;
    lcm_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_q_valid), .i_job(w_q_job),
        .o_valid(w_b_valid), .o_res(w_b_res)
    );

    logic       w_d_valid;
    t_res       w_d_res;
    logic [3:0] w_digits [DIGIT_COUNT];
    lcm_digits #(.DIGIT_COUNT(DIGIT_COUNT)) u_digits (
        .i_clk, .i_rst_n, .i_valid(w_b_valid), .i_res(w_b_res),
        .o_valid(w_d_valid), .o_res(w_d_res), .o_digits(w_digits)
    );

    // pad digits past the configured count with zero
    logic [3:0] w_dig8 [8];
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_dig8[k] = 4'd0;
        end
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (k < 8) begin
                w_dig8[k] = w_digits[k];
            end
        end
    end

    assign o_result_strobe = w_d_valid;
    assign o_value         = w_d_res.value;
    assign o_saturated     = w_d_res.saturated;
    assign o_count_clamped = w_d_res.clamped;
    assign o_digit0 = w_dig8[0];
    assign o_digit1 = w_dig8[1];
    assign o_digit2 = w_dig8[2];
    assign o_digit3 = w_dig8[3];
    assign o_digit4 = w_dig8[4];
    assign o_digit5 = w_dig8[5];
    assign o_digit6 = w_dig8[6];
    assign o_digit7 = w_dig8[7];

    // a saturated result is either all ones or zero
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_saturated) |->
            (o_value == 32'hFFFF_FFFF || o_value == 32'd0))
        else $error("saturated result with ordinary value");
    // accepted item enters the front stage next cycle
    a_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_f_valid)
        else $error("front stage lost an item");
    // nothing leaves the queue that was not pushed
    a_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid |-> $past(w_f_valid))
        else $error("queue invented an item");
endmodule
`default_nettype wire

[hdl/lcm_front.sv]
// Front end: clamp count, pick scale, square the reference.
`default_nettype none
module lcm_front
    import lcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_operation,
    input  wire logic [15:0] i_measured_count,
    input  wire logic [15:0] i_reference,
    input  wire logic [15:0] i_floor,
    input  wire logic [15:0] i_ind_scale,
    input  wire logic [15:0] i_cap_scale,
    output logic             o_valid,
    output t_job             o_job
);
    logic [15:0] w_lim;
    logic [15:0] w_c;
    t_job        n_job;
    logic        r_valid;
    t_job        r_job;

    always_comb begin
        w_lim = (i_measured_count > i_reference) ? i_reference : i_measured_count;
        w_c   = (w_lim < i_floor) ? i_floor : w_lim;
        n_job.ref_sq  = i_reference * i_reference;
        n_job.count   = w_c;
        n_job.scale   = (i_operation == OP_CAPACITANCE) ? i_cap_scale : i_ind_scale;
        n_job.zero    = (w_c == 16'd0);
        n_job.clamped = (w_c != i_measured_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule
`default_nettype wire

[hdl/lcm_fifo.sv]
// Short queue between front and back end.
`default_nettype none
module lcm_fifo
    import lcm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_valid,
    output t_job      o_job
);
    // back end never stalls, so one register stage suffices
    logic r_valid;
    t_job r_job;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_push;
        end
        if (i_push) begin
            r_job <= i_job;
        end
    end
    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule
`default_nettype wire

[hdl/lcm_back.sv]
// Back end: two pipelined restoring dividers, scale multiply, subtract and saturation.
`default_nettype none
module lcm_back
    import lcm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_job      i_job,
    output logic      o_valid,
    output t_res      o_res
);
    localparam int unsigned ST1 = 32; // quotient bits of ref^2/c
    localparam int unsigned ST2 = 48; // quotient bits of q1*s/c

    // divider 1: one quotient bit per stage
    logic [ST1:1]  r1_v;
    logic [31:0]   r1_n   [1:ST1];
    logic [16:0]   r1_rem [1:ST1];
    logic [31:0]   r1_q   [1:ST1];
    logic [15:0]   r1_d   [1:ST1];
    logic [15:0]   r1_s   [1:ST1];
    logic [ST1:1]  r1_z;
    logic [ST1:1]  r1_cl;

    genvar g;
    generate
        for (g = 0; g < ST1; g++) begin : g_div1
            logic        w_v;
            logic [31:0] w_n;
            logic [16:0] w_rem;
            logic [31:0] w_q;
            logic [15:0] w_d;
            logic [15:0] w_s;
            logic        w_z;
            logic        w_cl;
            logic [16:0] w_t;
            if (g == 0) begin : g_in
                assign w_v   = i_valid;
                assign w_n   = i_job.ref_sq;
                assign w_rem = 17'd0;
                assign w_q   = 32'd0;
                assign w_d   = i_job.count;
                assign w_s   = i_job.scale;
                assign w_z   = i_job.zero;
                assign w_cl  = i_job.clamped;
            end else begin : g_in
                assign w_v   = r1_v[g];
                assign w_n   = r1_n[g];
                assign w_rem = r1_rem[g];
                assign w_q   = r1_q[g];
                assign w_d   = r1_d[g];
                assign w_s   = r1_s[g];
                assign w_z   = r1_z[g];
                assign w_cl  = r1_cl[g];
            end
            assign w_t = {w_rem[15:0], w_n[31]};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r1_v[g+1] <= 1'b0;
                end else begin
                    r1_v[g+1] <= w_v;
                end
                r1_n[g+1] <= {w_n[30:0], 1'b0};
                if (w_t >= {1'b0, w_d}) begin
                    r1_rem[g+1] <= w_t - {1'b0, w_d};
                    r1_q[g+1]   <= {w_q[30:0], 1'b1};
                end else begin
                    r1_rem[g+1] <= w_t;
                    r1_q[g+1]   <= {w_q[30:0], 1'b0};
                end
                r1_d[g+1]  <= w_d;
                r1_s[g+1]  <= w_s;
                r1_z[g+1]  <= w_z;
                r1_cl[g+1] <= w_cl;
            end
        end
    endgenerate

    // multiply stage
    logic        rm_v;
    logic [47:0] rm_p;
    logic [15:0] rm_d;
    logic [15:0] rm_s;
    logic        rm_z;
    logic        rm_cl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_v <= 1'b0;
        end else begin
            rm_v <= r1_v[ST1];
        end
        rm_p  <= r1_q[ST1] * r1_s[ST1];
        rm_d  <= r1_d[ST1];
        rm_s  <= r1_s[ST1];
        rm_z  <= r1_z[ST1];
        rm_cl <= r1_cl[ST1];
    end

    // divider 2
    logic [ST2:1]  r2_v;
    logic [47:0]   r2_n   [1:ST2];
    logic [16:0]   r2_rem [1:ST2];
    logic [47:0]   r2_q   [1:ST2];
    logic [15:0]   r2_d   [1:ST2];
    logic [15:0]   r2_s   [1:ST2];
    logic [ST2:1]  r2_z;
    logic [ST2:1]  r2_cl;
    generate
        for (g = 0; g < ST2; g++) begin : g_div2
            logic        w_v;
            logic [47:0] w_n;
            logic [16:0] w_rem;
            logic [47:0] w_q;
            logic [15:0] w_d;
            logic [15:0] w_s;
            logic        w_z;
            logic        w_cl;
            logic [16:0] w_t;
            if (g == 0) begin : g_in
                assign w_v   = rm_v;
                assign w_n   = rm_p;
                assign w_rem = 17'd0;
                assign w_q   = 48'd0;
                assign w_d   = rm_d;
                assign w_s   = rm_s;
                assign w_z   = rm_z;
                assign w_cl  = rm_cl;
            end else begin : g_in
                assign w_v   = r2_v[g];
                assign w_n   = r2_n[g];
                assign w_rem = r2_rem[g];
                assign w_q   = r2_q[g];
                assign w_d   = r2_d[g];
                assign w_s   = r2_s[g];
                assign w_z   = r2_z[g];
                assign w_cl  = r2_cl[g];
            end
            assign w_t = {w_rem[15:0], w_n[47]};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r2_v[g+1] <= 1'b0;
                end else begin
                    r2_v[g+1] <= w_v;
                end
                r2_n[g+1] <= {w_n[46:0], 1'b0};
                if (w_t >= {1'b0, w_d}) begin
                    r2_rem[g+1] <= w_t - {1'b0, w_d};
                    r2_q[g+1]   <= {w_q[46:0], 1'b1};
                end else begin
                    r2_rem[g+1] <= w_t;
                    r2_q[g+1]   <= {w_q[46:0], 1'b0};
                end
                r2_d[g+1]  <= w_d;
                r2_s[g+1]  <= w_s;
                r2_z[g+1]  <= w_z;
                r2_cl[g+1] <= w_cl;
            end
        end
    endgenerate

    // subtract, floor and saturate
    logic [47:0] w_q2;
    logic [47:0] w_diff;
    t_res        n_res;
    t_res        r_res;
    logic        r_valid;
    always_comb begin
        w_q2   = r2_q[ST2];
        w_diff = w_q2 - {32'd0, r2_s[ST2]};
        n_res.clamped = r2_cl[ST2];
        if (r2_z[ST2]) begin
            n_res.value = 32'hFFFF_FFFF;
            n_res.saturated = 1'b1;
        end else if (w_q2 < {32'd0, r2_s[ST2]}) begin
            n_res.value = 32'd0;
            n_res.saturated = 1'b1;
        end else if (w_diff[47:32] != 16'd0) begin
            n_res.value = 32'hFFFF_FFFF;
            n_res.saturated = 1'b1;
        end else begin
            n_res.value = w_diff[31:0];
            n_res.saturated = 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r2_v[ST2];
        end
        r_res <= n_res;
    end
    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule
`default_nettype wire

[hdl/lcm_digits.sv]
// Decimal digit extraction, one digit per pipeline stage.
`default_nettype none
module lcm_digits
    import lcm_pkg::*;
#(
    parameter int unsigned DIGIT_COUNT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  t_res             i_res,
    output logic             o_valid,
    output t_res             o_res,
    output logic [3:0]       o_digits [DIGIT_COUNT]
);
    logic [DIGIT_COUNT:1] r_v;
    logic [31:0]          r_rem [1:DIGIT_COUNT];
    t_res                 r_res [1:DIGIT_COUNT];
    logic [3:0]           r_dig [1:DIGIT_COUNT][DIGIT_COUNT];

    genvar g;
    generate
        for (g = 0; g < DIGIT_COUNT; g++) begin : g_dig
            logic        w_v;
            logic [31:0] w_rem;
            t_res        w_res;
            logic [3:0]  w_dig [DIGIT_COUNT];
            // divide by ten through reciprocal multiply
            logic [63:0] w_prod;
            logic [31:0] w_quo;
            logic [31:0] w_mod;
            if (g == 0) begin : g_in
                assign w_v   = i_valid;
                assign w_rem = i_res.value;
                assign w_res = i_res;
                assign w_dig = '{default: 4'd0};
            end else begin : g_in
                assign w_v   = r_v[g];
                assign w_rem = r_rem[g];
                assign w_res = r_res[g];
                assign w_dig = r_dig[g];
            end
            assign w_prod = {32'd0, w_rem} * 64'hCCCC_CCCD;
            assign w_quo  = {3'd0, w_prod[63:35]};
            assign w_mod  = w_rem - (w_quo * 32'd10);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g+1] <= 1'b0;
                end else begin
                    r_v[g+1] <= w_v;
                end
                r_rem[g+1] <= w_quo;
                r_res[g+1] <= w_res;
                for (int k = 0; k < DIGIT_COUNT; k++) begin
                    r_dig[g+1][k] <= (k == g) ? w_mod[3:0] : w_dig[k];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[DIGIT_COUNT];
    assign o_res   = r_res[DIGIT_COUNT];
    always_comb begin
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            o_digits[k] = r_dig[DIGIT_COUNT][k];
        end
    end
endmodule
`default_nettype wire
